// ----- rtl/core/gmr1_pkg.sv -----
// gmr1_pkg: shared types, codes and lfsr helpers for the gmr-1 a5/1 keystream unit
// no dependencies; compiled first, imported by every module of the block

package gmr1_pkg;

    // register widths
    localparam int unsigned ONE_W   = 19;
    localparam int unsigned TWO_W   = 22;
    localparam int unsigned THREE_W = 23;
    localparam int unsigned CTL_W   = 17;

    // feedback taps
    localparam logic [ONE_W-1:0]   TAPS_ONE   = 19'h72000;
    localparam logic [TWO_W-1:0]   TAPS_TWO   = 22'h311000;
    localparam logic [THREE_W-1:0] TAPS_THREE = 23'h660000;
    localparam logic [CTL_W-1:0]   TAPS_CTL   = 17'h13100;

    // payload widths
    localparam int unsigned KEY_W  = 64;
    localparam int unsigned FN_W   = 19;
    localparam int unsigned BITS_W = 7;

    // largest bit count per generate request
    localparam logic [BITS_W-1:0] MAX_BITS = 7'd64;

    // configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY = 1'b1;

    // cipher mode codes
    localparam logic MODE_A50 = 1'b0;
    localparam logic MODE_A51 = 1'b1;

    // request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_GEN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_SEED,
        ST_MIX,
        ST_GEN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic init_frame;
        logic key_step;
        logic seed;
        logic mix_step;
        logic init_gen;
        logic gen_step;
        logic push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode_a51;
        logic start_req;
        logic has_bits;
        logic key_last;
        logic mix_last;
        logic gen_last;
        logic out_free;
    } status_t;

    // one plain clock of each register
    function automatic logic [ONE_W-1:0] clk_one(input logic [ONE_W-1:0] r);
        return {r[ONE_W-2:0], ^(r & TAPS_ONE)};
    endfunction

    function automatic logic [TWO_W-1:0] clk_two(input logic [TWO_W-1:0] r);
        return {r[TWO_W-2:0], ^(r & TAPS_TWO)};
    endfunction

    function automatic logic [THREE_W-1:0] clk_three(input logic [THREE_W-1:0] r);
        return {r[THREE_W-2:0], ^(r & TAPS_THREE)};
    endfunction

    function automatic logic [CTL_W-1:0] clk_ctl(input logic [CTL_W-1:0] r);
        return {r[CTL_W-2:0], ^(r & TAPS_CTL)};
    endfunction

    function automatic logic maj3(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

    // frame key: swap adjacent key bytes, then fold in frame number fields
    function automatic logic [KEY_W-1:0] frame_key(input logic [KEY_W-1:0] k,
                                                   input logic [FN_W-1:0] fn);
        logic [KEY_W-1:0] w;
        logic [KEY_W-1:0] m;
        w = '0;
        m = '0;
        for (int p = 0; p < 4; p++)
        begin
            w[16*p +: 8]     = k[16*p + 8 +: 8];
            w[16*p + 8 +: 8] = k[16*p +: 8];
        end
        m[15:12] = fn[3:0];
        m[39:38] = fn[5:4];
        m[55:51] = fn[10:6];
        m[60:56] = fn[15:11];
        m[63:61] = fn[18:16];
        return w ^ m;
    endfunction

endpackage

// ----- rtl/core/gmr1_if.sv -----
// gmr1_req_if / gmr1_res_if: valid-ready channels of the keystream unit
// depends on gmr1_pkg for payload widths

interface gmr1_req_if;
    import gmr1_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [FN_W-1:0]   frame_number;
    logic [BITS_W-1:0] bits_wanted;

    modport source (output valid, output action, output frame_number,
                    output bits_wanted, input ready);
    modport sink (input valid, input action, input frame_number,
                  input bits_wanted, output ready);
endinterface

interface gmr1_res_if;
    import gmr1_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  keystream;
    logic [BITS_W-1:0] bits_valid;

    modport source (output valid, output keystream, output bits_valid, input ready);
    modport sink (input valid, input keystream, input bits_valid, output ready);
endinterface

// ----- rtl/core/gmr1_ctrl.sv -----
// gmr1_ctrl: sequencer for frame setup and keystream requests
// depends on gmr1_pkg (state_t, cmd_t, status_t)

module gmr1_ctrl
    import gmr1_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (status.start_req)
                    begin
                        if (status.mode_a51)
                        begin
                            state_next = ST_KEY;
                        end
                    end
                    else if (status.has_bits)
                    begin
                        state_next = status.mode_a51 ? ST_GEN : ST_DONE;
                    end
                end
            end
            ST_KEY:
            begin
                if (status.key_last)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (status.mix_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GEN:
            begin
                if (status.gen_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands and handshake
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.init_frame = status.start_req && status.mode_a51;
                    cmd.init_gen   = !status.start_req && status.has_bits;
                end
            end
            ST_KEY:
            begin
                cmd.key_step = 1'b1;
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
            end
            ST_MIX:
            begin
                cmd.mix_step = 1'b1;
            end
            ST_GEN:
            begin
                cmd.gen_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/gmr1_datapath.sv -----
// gmr1_datapath: config registers, four lfsrs, step counter, keystream word, result register
// depends on gmr1_pkg (cmd_t, status_t, lfsr helpers, frame_key)

module gmr1_datapath
    import gmr1_pkg::*;
#(
    parameter int unsigned MIX_ROUNDS = 250
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    input  logic                 req_action,
    input  logic [FN_W-1:0]      req_frame_number,
    input  logic [BITS_W-1:0]    req_bits_wanted,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic [KEY_W-1:0]     res_keystream,
    output logic [BITS_W-1:0]    res_bits_valid,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam int unsigned CNT_W = ($clog2(MIX_ROUNDS) > 6) ? $clog2(MIX_ROUNDS) : 6;
    localparam logic [CNT_W-1:0] KEY_LAST = CNT_W'(KEY_W - 1);
    localparam logic [CNT_W-1:0] MIX_LAST = CNT_W'(MIX_ROUNDS - 1);

    logic                 mode_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [ONE_W-1:0]     one_reg;
    logic [TWO_W-1:0]     two_reg;
    logic [THREE_W-1:0]   three_reg;
    logic [CTL_W-1:0]     ctl_reg;
    logic [KEY_W-1:0]     fkey_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BITS_W-1:0]    n_reg;
    logic [KEY_W-1:0]     ks_reg;
    logic                 res_valid_reg;
    logic [KEY_W-1:0]     res_ks_reg;
    logic [BITS_W-1:0]    res_n_reg;

    logic                 c0;
    logic                 c1;
    logic                 c2;
    logic                 mv;
    logic [ONE_W-1:0]     one_m;
    logic [TWO_W-1:0]     two_m;
    logic [THREE_W-1:0]   three_m;
    logic [CTL_W-1:0]     ctl_m;
    logic                 ks_bit;
    logic                 key_bit;
    logic [BITS_W-1:0]    n_sat;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_A50;
            key_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CIPHER_MODE: mode_reg <= cfg_data[0];
                CFG_SESSION_KEY: key_reg  <= cfg_data;
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

    // majority clocking and output bit from the clocked values
    always_comb
    begin
        c0      = ctl_reg[15];
        c1      = ctl_reg[6];
        c2      = ctl_reg[1];
        mv      = maj3(c0, c1, c2);
        one_m   = (c0 == mv) ? clk_one(one_reg) : one_reg;
        two_m   = (c1 == mv) ? clk_two(two_reg) : two_reg;
        three_m = (c2 == mv) ? clk_three(three_reg) : three_reg;
        ctl_m   = clk_ctl(ctl_reg);
        ks_bit  = (maj3(one_m[1], one_m[6], one_m[15]) ^ one_m[11])
                ^ (maj3(two_m[3], two_m[8], two_m[14]) ^ two_m[1])
                ^ (maj3(three_m[4], three_m[15], three_m[19]) ^ three_m[0]);
        key_bit = fkey_reg[KEY_W-1];
        n_sat   = (req_bits_wanted > MAX_BITS) ? MAX_BITS : req_bits_wanted;
    end

    // lfsr state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg   <= '0;
            two_reg   <= '0;
            three_reg <= '0;
            ctl_reg   <= '0;
        end
        else if (cmd.init_frame)
        begin
            one_reg   <= '0;
            two_reg   <= '0;
            three_reg <= '0;
            ctl_reg   <= '0;
        end
        else if (cmd.key_step)
        begin
            one_reg   <= clk_one(one_reg) ^ ONE_W'(key_bit);
            two_reg   <= clk_two(two_reg) ^ TWO_W'(key_bit);
            three_reg <= clk_three(three_reg) ^ THREE_W'(key_bit);
            ctl_reg   <= clk_ctl(ctl_reg) ^ CTL_W'(key_bit);
        end
        else if (cmd.seed)
        begin
            one_reg[0]   <= 1'b1;
            two_reg[0]   <= 1'b1;
            three_reg[0] <= 1'b1;
            ctl_reg[0]   <= 1'b1;
        end
        else if (cmd.mix_step || cmd.gen_step)
        begin
            one_reg   <= one_m;
            two_reg   <= two_m;
            three_reg <= three_m;
            ctl_reg   <= ctl_m;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.init_frame || cmd.init_gen || cmd.seed)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.key_step || cmd.mix_step || cmd.gen_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // frame key shifter, bit count and keystream word
    always_ff @(posedge clk)
    begin
        if (cmd.init_frame)
        begin
            fkey_reg <= frame_key(key_reg, req_frame_number);
        end
        else if (cmd.key_step)
        begin
            fkey_reg <= {fkey_reg[KEY_W-2:0], 1'b0};
        end

        if (cmd.init_gen)
        begin
            n_reg  <= n_sat;
            ks_reg <= '0;
        end
        else if (cmd.gen_step)
        begin
            ks_reg[cnt_reg[5:0]] <= ks_bit;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            res_ks_reg <= ks_reg;
            res_n_reg  <= n_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign res_keystream  = res_ks_reg;
    assign res_bits_valid = res_n_reg;

    // status to the controller
    always_comb
    begin
        status.mode_a51  = (mode_reg == MODE_A51);
        status.start_req = (req_action == ACT_START);
        status.has_bits  = (req_bits_wanted != '0);
        status.key_last  = (cnt_reg == KEY_LAST);
        status.mix_last  = (cnt_reg == MIX_LAST);
        status.gen_last  = (cnt_reg == CNT_W'(n_reg - BITS_W'(1)));
        status.out_free  = !res_valid_reg || res_ready;
    end

endmodule

// ----- rtl/core/gmr1_a51_keystream_generator_unit.sv -----
// gmr1_a51_keystream_generator_unit: top level of the gmr-1 a5/1 keystream unit
// depends on gmr1_pkg, gmr1_if, gmr1_ctrl and gmr1_datapath
//
// Usage:
//   req channel (valid/ready) carries action, frame_number and bits_wanted.
//   res channel (valid/ready) returns keystream (first bit in bit 0) and bits_valid.
//   cfg_we/cfg_index/cfg_data write cipher_mode (index 0) and session_key
//   (index 1); write them only while the unit is idle.
// Request handling:
//   start request in a5/1 mode: ready drops while the lfsrs load the 64
//   frame key bits, take the seed bits and run MIX_ROUNDS mixing rounds; in
//   a5/0 mode it is taken and dropped.
//   generate request of n bits: one lfsr clock per bit; the bits then go to
//   the result register once it is free, and ready returns after that load.
//   a5/0 mode skips the clocks. A request with zero bits gives no result.
//   The single lfsr set bounds the rate: one request at a time, a new one is
//   taken only when the last one is through.
// Reset: lfsrs, cipher_mode and session_key clear to zero, no result pending.
// Stall: a finished result waits in the result register; the next request is
//   still taken, and a later result waits until the held one is taken.

module gmr1_a51_keystream_generator_unit
    import gmr1_pkg::*;
#(
    parameter int unsigned MIX_ROUNDS = 250
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    gmr1_req_if.sink             req,
    gmr1_res_if.source           res
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    gmr1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // lfsrs and result path
    gmr1_datapath #(
        .MIX_ROUNDS (MIX_ROUNDS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_action       (req.action),
        .req_frame_number (req.frame_number),
        .req_bits_wanted  (req.bits_wanted),
        .res_ready        (res.ready),
        .res_valid        (res.valid),
        .res_keystream    (res.keystream),
        .res_bits_valid   (res.bits_valid),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// ----- rtl/core/gmr1_checker.sv -----
// gmr1_checker: port-level checks of the keystream unit, bound to the top level
// depends on gmr1_pkg and gmr1_a51_keystream_generator_unit

module gmr1_checker
    import gmr1_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              req_action,
    input logic [BITS_W-1:0] req_bits_wanted,
    input logic              res_valid,
    input logic              res_ready,
    input logic [KEY_W-1:0]  res_keystream,
    input logic [BITS_W-1:0] res_bits_valid
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_keystream)
                                    && $stable(res_bits_valid))
        else $error("result changed while stalled");

    // bit count within range
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_bits_valid != '0 && res_bits_valid <= MAX_BITS)
        else $error("bits_valid out of range");

    // bits beyond the count are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_keystream >> res_bits_valid) == '0)
        else $error("keystream has bits beyond bits_valid");

    // a zero-bit request raises no result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_action == ACT_GEN && req_bits_wanted == '0
        |=> !$rose(res_valid))
        else $error("result raised for zero-bit request");

endmodule

bind gmr1_a51_keystream_generator_unit gmr1_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_action      (req.action),
    .req_bits_wanted (req.bits_wanted),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_keystream   (res.keystream),
    .res_bits_valid  (res.bits_valid)
);
